// ===== design/triangle_barycentric_weights_unit_macros.svh =====
// Assertion macros shared by the checker.
`ifndef TRIANGLE_BARYCENTRIC_WEIGHTS_UNIT_MACROS_SVH
`define TRIANGLE_BARYCENTRIC_WEIGHTS_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define TBW_ASSERT_IMPL(label, clk_s, rst_s, lhs, rhs, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define TBW_ASSERT_NEXT(label, clk_s, rst_s, lhs, rhs, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ===== design/tbw_pkg.sv =====
package tbw_pkg;

    localparam int CoordBitsDefault = 16;
    localparam int WeightFracBitsDefault = 16;
    localparam int FieldBits = 16;
    localparam int WeightBits = 18;
    localparam int QueueDepth = 2;

    typedef struct packed {
        logic signed [FieldBits-1:0] point_x;
        logic signed [FieldBits-1:0] point_y;
        logic signed [FieldBits-1:0] vert_a_x;
        logic signed [FieldBits-1:0] vert_a_y;
        logic signed [FieldBits-1:0] vert_b_x;
        logic signed [FieldBits-1:0] vert_b_y;
        logic signed [FieldBits-1:0] vert_c_x;
        logic signed [FieldBits-1:0] vert_c_y;
    } tbw_in_t;

    typedef struct packed {
        logic [WeightBits-1:0] weight_a;
        logic [WeightBits-1:0] weight_b;
        logic [WeightBits-1:0] weight_c;
        logic                  degenerate;
        logic                  clipped;
    } tbw_out_t;

    // Queue occupancy handshake between front and back.
    typedef struct packed {
        logic push;
        logic full;
    } tbw_q_ctl_t;

endpackage

// ===== design/tbw_front.sv =====
// Front: sign-adjust coordinates, form the four cross products, take magnitudes.
// Two register stages with valid/stall; the stage holds on stall.
module tbw_front
    import tbw_pkg::*;
#(
    parameter int COORD_BITS = CoordBitsDefault,
    parameter int AREA_BITS  = 2 * COORD_BITS + 2
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  tbw_in_t              in_data,
    output logic                 f_valid,
    input  logic                 f_stall,
    output logic [AREA_BITS-1:0] f_sa,
    output logic [AREA_BITS-1:0] f_sb,
    output logic [AREA_BITS-1:0] f_sc,
    output logic [AREA_BITS-1:0] f_s
);
    localparam int DB = COORD_BITS + 1;
    localparam int PB = 2 * DB;

    logic signed [DB-1:0] d_reg [12];
    logic signed [DB-1:0] d_next [12];
    logic                 v1_reg;
    logic                 v2_reg;
    logic [AREA_BITS-1:0] sa_reg, sb_reg, sc_reg, s_reg;
    logic                 adv1, adv2;

    function automatic logic signed [DB-1:0] crd(input logic [FieldBits-1:0] raw);
        logic [31:0]           wide;
        logic [COORD_BITS-1:0] low;
        wide = 32'(raw);
        low = wide[COORD_BITS-1:0];
        return DB'(signed'(low));
    endfunction

    function automatic logic [AREA_BITS-1:0] acr(
        input logic signed [DB-1:0] ux, input logic signed [DB-1:0] uy,
        input logic signed [DB-1:0] vx, input logic signed [DB-1:0] vy);
        logic signed [PB-1:0] p0;
        logic signed [PB-1:0] p1;
        logic signed [PB:0]   c;
        p0 = ux * vy;
        p1 = uy * vx;
        c = (PB+1)'(p0) - (PB+1)'(p1);
        return c[PB] ? AREA_BITS'(-c) : AREA_BITS'(c);
    endfunction

    always_comb
    begin
        logic signed [DB-1:0] px, py, ax, ay, bx, by, cx, cy;
        px = crd(in_data.point_x);  py = crd(in_data.point_y);
        ax = crd(in_data.vert_a_x); ay = crd(in_data.vert_a_y);
        bx = crd(in_data.vert_b_x); by = crd(in_data.vert_b_y);
        cx = crd(in_data.vert_c_x); cy = crd(in_data.vert_c_y);
        d_next[0]  = cx - bx; d_next[1]  = cy - by;
        d_next[2]  = px - bx; d_next[3]  = py - by;
        d_next[4]  = ax - cx; d_next[5]  = ay - cy;
        d_next[6]  = px - cx; d_next[7]  = py - cy;
        d_next[8]  = bx - ax; d_next[9]  = by - ay;
        d_next[10] = px - ax; d_next[11] = py - ay;
    end

    // Hold a stage when the one after it is full and stalled.
    assign adv2     = !v2_reg || !f_stall;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid) d_reg <= d_next;
        if (adv2 && v1_reg)
        begin
            sa_reg <= acr(d_reg[0], d_reg[1], d_reg[2], d_reg[3]);
            sb_reg <= acr(d_reg[4], d_reg[5], d_reg[6], d_reg[7]);
            sc_reg <= acr(d_reg[8], d_reg[9], d_reg[10], d_reg[11]);
            s_reg  <= acr(d_reg[8], d_reg[9], d_reg[0] + d_reg[8], d_reg[1] + d_reg[9]);
        end
    end

    assign f_valid = v2_reg;
    assign f_sa = sa_reg;
    assign f_sb = sb_reg;
    assign f_sc = sc_reg;
    assign f_s  = s_reg;
endmodule

// ===== design/tbw_queue.sv =====
// Short FIFO between front and back.
module tbw_queue
    import tbw_pkg::*;
#(
    parameter int WIDTH = 8
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_stall,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_stall,
    output logic [WIDTH-1:0] rd_data
);
    localparam int AW = $clog2(QueueDepth);

    logic [WIDTH-1:0] mem_reg [QueueDepth];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;
    tbw_q_ctl_t       ctl;
    logic             pop;

    assign ctl.full = (cnt_reg == (AW+1)'(QueueDepth));
    assign ctl.push = wr_valid && !ctl.full;
    assign pop      = rd_valid && !rd_stall;
    assign wr_stall = ctl.full;
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (ctl.push) wp_reg <= wp_reg + 1'b1;
            if (pop)      rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(ctl.push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push) mem_reg[wp_reg] <= wr_data;
    end
endmodule

// ===== design/tbw_back.sv =====
// Back: three pipelined restoring dividers sharing one divisor, then saturate.
// One quotient bit per stage; a seed stage, QB stages and an output register.
module tbw_back
    import tbw_pkg::*;
#(
    parameter int AREA_BITS = 34,
    parameter int WEIGHT_FRAC_BITS = WeightFracBitsDefault
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [AREA_BITS-1:0] sa,
    input  logic [AREA_BITS-1:0] sb,
    input  logic [AREA_BITS-1:0] sc,
    input  logic [AREA_BITS-1:0] s,
    output logic                 out_valid,
    input  logic                 out_stall,
    output tbw_out_t             out_data
);
    // Quotient bits kept: everything at or above bit 2+F only flags saturation.
    localparam int NB = AREA_BITS + WEIGHT_FRAC_BITS;
    localparam int QB = WEIGHT_FRAC_BITS + 3;
    localparam int RB = AREA_BITS + 1;
    localparam int HB = NB - QB;
    localparam logic [WeightBits:0] WMAXW =
        ((WeightBits+1)'(4) << WEIGHT_FRAC_BITS) - 1'b1;
    localparam logic [WeightBits:0] FMAX = (WeightBits+1)'((1 << WeightBits) - 1);
    localparam logic [WeightBits:0] WMAX = (WMAXW > FMAX) ? FMAX : WMAXW;

    typedef struct packed {
        logic [RB-1:0] rem;
        logic [QB-1:0] quo;
        logic [QB-1:0] rest;
        logic          hi;
    } lane_t;

    logic          v_reg   [QB+1];
    logic [RB-1:0] den_reg [QB+1];
    logic          deg_reg [QB+1];
    lane_t         ln_reg  [QB+1][3];
    logic          adv     [QB+1];
    logic          ov_reg;
    tbw_out_t      od_reg;
    logic          oadv;

    function automatic lane_t stage(input lane_t l, input logic [RB-1:0] d);
        lane_t         o;
        logic [RB:0]   sh;
        sh = {l.rem, l.rest[QB-1]};
        o  = l;
        o.rest = {l.rest[QB-2:0], 1'b0};
        if (sh >= {1'b0, d})
        begin
            o.rem = RB'(sh - {1'b0, d});
            o.quo = {l.quo[QB-2:0], 1'b1};
        end
        else
        begin
            o.rem = RB'(sh);
            o.quo = {l.quo[QB-2:0], 1'b0};
        end
        return o;
    endfunction

    // High dividend bits: quotient above 2^QB exists iff they reach the divisor.
    function automatic lane_t seed(input logic [AREA_BITS-1:0] a,
                                   input logic [AREA_BITS-1:0] d);
        lane_t         o;
        logic [NB-1:0] n;
        logic [HB-1:0] h;
        n = {a, WEIGHT_FRAC_BITS'(0)};
        h = n[NB-1:QB];
        o.hi   = (RB'(h) >= {1'b0, d}) && (HB >= RB || h >= HB'(d));
        o.rem  = o.hi ? '0 : RB'(h);
        o.quo  = '0;
        o.rest = n[QB-1:0];
        return o;
    endfunction

    function automatic logic [WeightBits:0] sat(input lane_t l, output logic c);
        logic big;
        big = l.hi || ((QB+1)'(l.quo) > (QB+1)'(WMAX));
        c = big;
        return big ? WMAX : (WeightBits+1)'(l.quo);
    endfunction

    assign oadv = !ov_reg || !out_stall;
    assign adv[QB] = !v_reg[QB] || oadv;
    for (genvar i = 0; i < QB; i++)
    begin : g_adv
        assign adv[i] = !v_reg[i] || adv[i+1];
    end
    assign in_stall = !adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= QB; i++) v_reg[i] <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (adv[0]) v_reg[0] <= in_valid;
            for (int i = 1; i <= QB; i++)
                if (adv[i]) v_reg[i] <= v_reg[i-1];
            if (oadv) ov_reg <= v_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
        begin
            den_reg[0]   <= RB'(s);
            deg_reg[0]   <= (s == '0);
            ln_reg[0][0] <= seed(sa, s);
            ln_reg[0][1] <= seed(sb, s);
            ln_reg[0][2] <= seed(sc, s);
        end
        for (int i = 1; i <= QB; i++)
            if (adv[i] && v_reg[i-1])
            begin
                den_reg[i] <= den_reg[i-1];
                deg_reg[i] <= deg_reg[i-1];
                for (int k = 0; k < 3; k++)
                    ln_reg[i][k] <= stage(ln_reg[i-1][k], den_reg[i-1]);
            end
        if (oadv && v_reg[QB])
        begin
            logic c0, c1, c2;
            logic [WeightBits:0] w0, w1, w2;
            w0 = sat(ln_reg[QB][0], c0);
            w1 = sat(ln_reg[QB][1], c1);
            w2 = sat(ln_reg[QB][2], c2);
            od_reg.degenerate <= deg_reg[QB];
            od_reg.weight_a   <= deg_reg[QB] ? '0 : WeightBits'(w0);
            od_reg.weight_b   <= deg_reg[QB] ? '0 : WeightBits'(w1);
            od_reg.weight_c   <= deg_reg[QB] ? '0 : WeightBits'(w2);
            od_reg.clipped    <= !deg_reg[QB] && (c0 || c1 || c2);
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
endmodule

// ===== design/triangle_barycentric_weights_unit.sv =====
// Barycentric weights by area ratio, one query point per transaction.
// Input channel in_valid/in_stall/in_data carries the point and the three
// vertices (signed Q12.4); output channel out_valid/out_stall/out_data
// carries weight_a..c (unsigned Q2.16, saturating), degenerate and clipped.
// A transaction is taken at a clock edge with valid high and stall low.
// Throughput: one transaction per clock, sustained while out_stall stays low.
// Path: the cross-product front, the queue, 1 seed stage, then
// WEIGHT_FRAC_BITS+3 divider stages plus the output register. The
// divider pipeline retires one quotient bit per stage.
// Reset empties every pipeline stage and the queue; no transaction is
// in flight afterwards. Payload registers are not cleared.
// When the receiver stalls, the output register holds its transaction,
// each pipeline stage fills behind it, the queue absorbs what the front
// still produces, and in_stall rises once the front can take no more.
module triangle_barycentric_weights_unit
    import tbw_pkg::*;
#(
    parameter int COORD_BITS       = CoordBitsDefault,
    parameter int WEIGHT_FRAC_BITS = WeightFracBitsDefault
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  tbw_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output tbw_out_t out_data
);
    localparam int AB = 2 * COORD_BITS + 2;

    logic          f_valid, f_stall, b_valid, b_stall;
    logic [AB-1:0] f_sa, f_sb, f_sc, f_s;
    logic [4*AB-1:0] q_out;

    tbw_front #(.COORD_BITS(COORD_BITS), .AREA_BITS(AB)) u_front (
        .clk, .rst_n, .in_valid, .in_stall, .in_data,
        .f_valid, .f_stall, .f_sa, .f_sb, .f_sc, .f_s
    );

    // Decouple the front from the divider pipeline.
    tbw_queue #(.WIDTH(4 * AB)) u_queue (
        .clk, .rst_n,
        .wr_valid(f_valid), .wr_stall(f_stall), .wr_data({f_sa, f_sb, f_sc, f_s}),
        .rd_valid(b_valid), .rd_stall(b_stall), .rd_data(q_out)
    );

    tbw_back #(.AREA_BITS(AB), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_back (
        .clk, .rst_n,
        .in_valid(b_valid), .in_stall(b_stall),
        .sa(q_out[4*AB-1:3*AB]), .sb(q_out[3*AB-1:2*AB]),
        .sc(q_out[2*AB-1:AB]), .s(q_out[AB-1:0]),
        .out_valid, .out_stall, .out_data
    );
endmodule

// ===== design/tbw_checker.sv =====
`include "triangle_barycentric_weights_unit_macros.svh"

module tbw_checker
    import tbw_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input tbw_out_t out_data
);
    `TBW_ASSERT_IMPL(a_deg_zero, clk, rst_n, out_valid && out_data.degenerate,
        out_data.weight_a == '0 && out_data.weight_b == '0 && out_data.weight_c == '0,
        "degenerate result with nonzero weight")
    `TBW_ASSERT_IMPL(a_deg_noclip, clk, rst_n, out_valid && out_data.degenerate,
        !out_data.clipped, "degenerate result flagged clipped")
    `TBW_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_data), "stalled result changed")
    `TBW_ASSERT_NEXT(a_free_flow, clk, rst_n, !out_valid && !out_stall,
        !in_stall || !in_valid, "input stalled while output side idle")
endmodule

bind triangle_barycentric_weights_unit tbw_checker u_tbw_checker (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
